// ===== src/jrs_pkg.sv =====
// shared types and character codes for the json re-indent stream
package jrs_pkg;

  localparam int NUM_SLOTS  = 5;
  localparam int SLOT_IDX_W = 3;
  localparam int DEPTH_W    = 8;
  localparam int INDENT_W   = 4;
  localparam int COUNT_W    = 10;
  localparam int PROD_W     = DEPTH_W + INDENT_W;

  localparam logic [INDENT_W-1:0] INDENT_MAX   = 4'd8;
  localparam logic [INDENT_W-1:0] INDENT_RESET = 4'd2;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 10'd1023;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_NEWLINE = 1'b1;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic               kind;
    logic [7:0]         data;
    logic [DEPTH_W-1:0] depth;
    logic               err;
  } slot_t;

  typedef struct packed {
    slot_t [NUM_SLOTS-1:0]  slots;
    logic [SLOT_IDX_W-1:0]  cnt;
  } cmd_t;

endpackage

// ===== src/jrs_front.sv =====
// front end: parses input bytes and builds at most one result command per byte
module jrs_front #(
  parameter int MAX_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic          in_full,
  input  logic [7:0]    in_byte,
  input  logic          in_last_byte,
  output logic          cmd_push,
  output jrs_pkg::cmd_t cmd
);
  import jrs_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);

  logic          str_r, str_nxt;
  logic          esc_r, esc_nxt;
  logic          pend_r, pend_nxt;
  logic          brace_r, brace_nxt;
  logic [DW-1:0] depth_r, depth_nxt;

  function automatic slot_t byte_slot(logic [7:0] b, logic e);
    slot_t s;
    s.kind  = KIND_BYTE;
    s.data  = b;
    s.depth = '0;
    s.err   = e;
    return s;
  endfunction

  function automatic slot_t nl_slot(logic [DW-1:0] d, logic e);
    slot_t s;
    s.kind  = KIND_NEWLINE;
    s.data  = '0;
    s.depth = DEPTH_W'(d);
    s.err   = e;
    return s;
  endfunction

  logic                  accept;
  logic [SLOT_IDX_W-1:0] n;
  logic                  go_pend;
  logic                  go_plain;
  logic                  run_plain;
  logic                  err;
  logic                  ws;
  logic [7:0]            pend_op;
  logic [7:0]            pend_cl;
  cmd_t                  c_cmd;

  assign accept  = in_push && !in_full;
  assign pend_op = brace_r ? CH_LBRACE : CH_LBRACK;
  assign pend_cl = brace_r ? CH_RBRACE : CH_RBRACK;
  assign ws      = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);

  always_comb begin
    str_nxt   = str_r;
    esc_nxt   = esc_r;
    pend_nxt  = pend_r;
    brace_nxt = brace_r;
    depth_nxt = depth_r;
    c_cmd     = '0;
    n         = '0;
    go_pend   = 1'b0;
    go_plain  = 1'b0;
    run_plain = 1'b0;
    err       = 1'b0;

    if (str_r) begin
      c_cmd.slots[n] = byte_slot(in_byte, 1'b0);
      n = n + SLOT_IDX_W'(1);
      if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (in_byte == CH_BSLASH) begin
        esc_nxt = 1'b1;
      end else if (in_byte == CH_QUOTE) begin
        str_nxt = 1'b0;
      end
    end else if (pend_r) begin
      if (ws) begin
        if (in_last_byte) begin
          pend_nxt = 1'b0;
          go_pend  = 1'b1;
        end
      end else if (in_byte == pend_cl) begin
        pend_nxt = 1'b0;
        c_cmd.slots[n] = byte_slot(pend_op, 1'b0);
        n = n + SLOT_IDX_W'(1);
        c_cmd.slots[n] = byte_slot(pend_cl, 1'b0);
        n = n + SLOT_IDX_W'(1);
      end else begin
        pend_nxt  = 1'b0;
        go_pend   = 1'b1;
        run_plain = 1'b1;
      end
    end else begin
      run_plain = 1'b1;
    end

    // held opener goes out before anything the current byte adds
    if (go_pend) begin
      err = (depth_nxt >= DW'(MAX_DEPTH));
      if (!err) depth_nxt = depth_nxt + DW'(1);
      c_cmd.slots[n] = byte_slot(pend_op, err);
      n = n + SLOT_IDX_W'(1);
      c_cmd.slots[n] = nl_slot(depth_nxt, err);
      n = n + SLOT_IDX_W'(1);
    end

    if (run_plain) begin
      unique case (in_byte) inside
        CH_QUOTE: begin
          str_nxt = 1'b1;
          esc_nxt = 1'b0;
          c_cmd.slots[n] = byte_slot(in_byte, 1'b0);
          n = n + SLOT_IDX_W'(1);
        end
        CH_LBRACE, CH_LBRACK: begin
          if (in_last_byte) begin
            go_plain = 1'b1;
          end else begin
            pend_nxt  = 1'b1;
            brace_nxt = (in_byte == CH_LBRACE);
          end
        end
        CH_RBRACE, CH_RBRACK: begin
          err = (depth_nxt == '0);
          if (!err) depth_nxt = depth_nxt - DW'(1);
          c_cmd.slots[n] = nl_slot(depth_nxt, err);
          n = n + SLOT_IDX_W'(1);
          c_cmd.slots[n] = byte_slot(in_byte, err);
          n = n + SLOT_IDX_W'(1);
        end
        CH_COMMA: begin
          c_cmd.slots[n] = byte_slot(in_byte, 1'b0);
          n = n + SLOT_IDX_W'(1);
          c_cmd.slots[n] = nl_slot(depth_nxt, 1'b0);
          n = n + SLOT_IDX_W'(1);
        end
        CH_COLON: begin
          c_cmd.slots[n] = byte_slot(CH_COLON, 1'b0);
          n = n + SLOT_IDX_W'(1);
          c_cmd.slots[n] = byte_slot(CH_SPACE, 1'b0);
          n = n + SLOT_IDX_W'(1);
        end
        CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
        end
        default: begin
          c_cmd.slots[n] = byte_slot(in_byte, 1'b0);
          n = n + SLOT_IDX_W'(1);
        end
      endcase
    end

    // opener on the final byte is not held
    if (go_plain) begin
      err = (depth_nxt >= DW'(MAX_DEPTH));
      if (!err) depth_nxt = depth_nxt + DW'(1);
      c_cmd.slots[n] = byte_slot(in_byte, err);
      n = n + SLOT_IDX_W'(1);
      c_cmd.slots[n] = nl_slot(depth_nxt, err);
      n = n + SLOT_IDX_W'(1);
    end

    if (in_last_byte) begin
      c_cmd.slots[n] = nl_slot('0, 1'b0);
      n = n + SLOT_IDX_W'(1);
      str_nxt   = 1'b0;
      esc_nxt   = 1'b0;
      pend_nxt  = 1'b0;
      brace_nxt = 1'b0;
      depth_nxt = '0;
    end

    c_cmd.cnt = n;
  end

  assign cmd      = c_cmd;
  assign cmd_push = accept && (n != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      str_r   <= 1'b0;
      esc_r   <= 1'b0;
      pend_r  <= 1'b0;
      brace_r <= 1'b0;
      depth_r <= '0;
    end else if (accept) begin
      str_r   <= str_nxt;
      esc_r   <= esc_nxt;
      pend_r  <= pend_nxt;
      brace_r <= brace_nxt;
      depth_r <= depth_nxt;
    end
  end

endmodule

// ===== src/jrs_cmd_fifo.sv =====
// short command queue between the front end and the result sequencer
module jrs_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jrs_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output jrs_pkg::cmd_t rd_cmd
);
  import jrs_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/jrs_back.sv =====
// result sequencer: walks each command one result per transfer
module jrs_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [jrs_pkg::INDENT_W-1:0]   cfg_indent_width,
  input  logic                           q_empty,
  input  jrs_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_kind,
  output logic [7:0]                     out_byte,
  output logic [jrs_pkg::COUNT_W-1:0]    out_space_count,
  output logic                           out_depth_error,
  output logic                           out_run_last
);
  import jrs_pkg::*;

  logic [INDENT_W-1:0]   indent_r;
  cmd_t                  cur_r;
  logic [SLOT_IDX_W-1:0] idx_r;
  logic                  vld_r;

  slot_t                 s;
  logic                  is_last;
  logic                  take;
  logic [INDENT_W-1:0]   iw;
  logic [PROD_W-1:0]     prod;

  assign s       = cur_r.slots[idx_r];
  assign is_last = (idx_r == cur_r.cnt - SLOT_IDX_W'(1));
  assign take    = vld_r && out_pop;
  assign q_pop   = !q_empty && (!vld_r || (take && is_last));

  assign iw   = (indent_r > INDENT_MAX) ? INDENT_MAX : indent_r;
  assign prod = PROD_W'(s.depth) * PROD_W'(iw);

  assign out_empty       = !vld_r;
  assign out_kind        = s.kind;
  assign out_byte        = s.data;
  assign out_depth_error = s.err;
  assign out_run_last    = is_last;

  always_comb begin
    if (s.kind != KIND_NEWLINE) begin
      out_space_count = '0;
    end else if (prod > PROD_W'(COUNT_MAX)) begin
      out_space_count = COUNT_MAX;
    end else begin
      out_space_count = prod[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      indent_r <= INDENT_RESET;
      idx_r    <= '0;
      vld_r    <= 1'b0;
    end else begin
      if (cfg_we) indent_r <= cfg_indent_width;
      if (q_pop) begin
        idx_r <= '0;
        vld_r <= 1'b1;
      end else if (take) begin
        if (is_last) begin
          vld_r <= 1'b0;
        end else begin
          idx_r <= idx_r + SLOT_IDX_W'(1);
        end
      end
    end
  end

endmodule

// ===== src/json_reindent_stream.sv =====
// top level of the streaming json re-indenter
// Takes one JSON text byte per cycle whenever in_full is low and produces a
// re-indented stream of results, each either a literal byte or a newline
// with a space count of nesting depth times the indent width. Each byte
// yields zero to five results; results leave one per cycle while out_pop
// is high, and QUEUE_DEPTH commands between the parser and the result
// sequencer absorb bursts. A byte's first result reaches the result ports
// once its command moves from the queue into the sequencer. indent_width is
// written via cfg_we only while the block is idle; the user must ensure it.
module json_reindent_stream #(
  parameter int MAX_DEPTH   = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [jrs_pkg::INDENT_W-1:0] cfg_indent_width,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [7:0]                   in_byte,
  input  logic                         in_last_byte,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic                         out_kind,
  output logic [7:0]                   out_byte,
  output logic [jrs_pkg::COUNT_W-1:0]  out_space_count,
  output logic                         out_depth_error,
  output logic                         out_run_last
);
  import jrs_pkg::*;

  logic cmd_push;
  cmd_t cmd;
  logic q_pop;
  logic q_empty;
  cmd_t q_cmd;

  jrs_front #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .cmd_push     (cmd_push),
    .cmd          (cmd)
  );

  jrs_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_cmd (cmd),
    .full   (in_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_cmd (q_cmd)
  );

  jrs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_indent_width (cfg_indent_width),
    .q_empty          (q_empty),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_space_count  (out_space_count),
    .out_depth_error  (out_depth_error),
    .out_run_last     (out_run_last)
  );

endmodule
